[hw/rtl/bpc_pkg.sv]
// Package: shared types and constants of the barometer compensation pipeline.
`default_nettype none
package bpc_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] RegTempCal   = 2'd0;
  localparam logic [1:0] RegPressLow  = 2'd1;
  localparam logic [1:0] RegPressHigh = 2'd2;
  localparam logic [1:0] RegPressLast = 2'd3;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 64;

  // Compensation constants
  localparam logic signed [33:0] TempOffset = 34'sd128000;
  localparam logic [20:0]        PressBase  = 21'd1048576;
  localparam logic signed [63:0] PressScale = 64'sd3125;
  localparam logic signed [63:0] VarBias    = 64'sh0000_8000_0000_0000;

  // Decoded calibration words
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } bpc_cal_t;

  // Payload that travels beside the pressure datapath
  typedef struct packed {
    logic [31:0] temp;
    logic        err;
  } bpc_side_t;

  function automatic logic signed [63:0] sext16(input logic [15:0] v);
    sext16 = {{48{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/bpc_stream_if.sv]
// Interfaces: raw sample channel and compensated result channel.
`default_nettype none
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_pressure;
  logic [19:0] raw_temperature;
  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic [31:0]        pressure_q24_8;
  logic               divide_error;
  modport source (output valid, output temperature_centi, output pressure_q24_8,
                  output divide_error, input ready);
  modport sink   (input valid, input temperature_centi, input pressure_q24_8,
                  input divide_error, output ready);
endinterface
`default_nettype wire

[hw/rtl/baro_pressure_temp_compensation.sv]
// Barometer compensation: raw pressure and temperature in, compensated values out.
// Usage:
//   in_i carries one raw 20-bit pressure and temperature pair per transfer
//   (valid/ready); out_o returns temperature in 0.01 degC and pressure in Pa
//   as unsigned Q24.8, with divide_error set and both values zero when the
//   pressure divisor comes out as zero.
//   The calibration words are written over the APB port (registers at byte
//   addresses 0, 8, 16 and 24) while no sample is in flight.
// Timing:
//   From an input transfer to the result showing on out_o there are
//   12 front stages (temperature and divisor/dividend products), 64
//   divider stages of one quotient bit each, and 5 back stages ending in the
//   output register. One pair is taken every cycle unless out_o stalls.
// Reset and stalls:
//   Reset clears all calibration registers to zero and empties the pipeline.
//   While a result waits and out_o.ready is low, the whole pipeline holds and
//   in_i.ready falls; nothing is dropped or repeated.
`default_nettype none
module baro_pressure_temp_compensation (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  bpc_in_if.sink                                 in_i,
  bpc_out_if.source                              out_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bpc_pkg::AddrWidth-1:0]     paddr,
  input  wire logic [bpc_pkg::DataWidth-1:0]     pwdata,
  output logic      [bpc_pkg::DataWidth-1:0]     prdata,
  output logic                                   pready
);

  bpc_pkg::bpc_cal_t  cal;
  bpc_pkg::bpc_side_t fr_side, dv_side;
  logic               en, fr_valid, fr_neg, dv_valid, dv_neg;
  logic [63:0]        fr_num, fr_den, dv_quot;
  logic               out_valid, out_err;
  logic [31:0]        out_temp, out_press;

  // advance everything unless a result is waiting
  assign en = ~out_valid | out_o.ready;

  bpc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cal_o (cal)
  );

  bpc_front u_front (
    .clk_i, .rst_ni,
    .en_i              (en),
    .valid_i           (in_i.valid),
    .raw_pressure_i    (in_i.raw_pressure),
    .raw_temperature_i (in_i.raw_temperature),
    .cal_i             (cal),
    .valid_o           (fr_valid),
    .side_o            (fr_side),
    .num_mag_o         (fr_num),
    .den_mag_o         (fr_den),
    .neg_o             (fr_neg)
  );

  bpc_div u_div (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (fr_valid),
    .side_i  (fr_side),
    .num_i   (fr_num),
    .den_i   (fr_den),
    .neg_i   (fr_neg),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quot_o  (dv_quot),
    .neg_o   (dv_neg)
  );

  bpc_back u_back (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (dv_valid),
    .side_i  (dv_side),
    .quot_i  (dv_quot),
    .neg_i   (dv_neg),
    .cal_i   (cal),
    .valid_o (out_valid),
    .temp_o  (out_temp),
    .press_o (out_press),
    .err_o   (out_err)
  );

  assign in_i.ready              = en;
  assign out_o.valid             = out_valid;
  assign out_o.temperature_centi = out_temp;
  assign out_o.pressure_q24_8    = out_press;
  assign out_o.divide_error      = out_err;

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_err) |-> (out_temp == '0 && out_press == '0))
    else $error("divide error result not zeroed");

  a_ready_follows_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == (!out_valid || out_o.ready))
    else $error("input ready disagrees with output stall");

  a_empty_after_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid)
    else $error("result valid straight after reset");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_valid && !en) |=> dv_valid)
    else $error("divider output lost during stall");

endmodule
`default_nettype wire

[hw/rtl/bpc_cfg_regs.sv]
// Calibration register file behind the APB-style read/write port.
`default_nettype none
module bpc_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bpc_pkg::AddrWidth-1:0]     paddr,
  input  wire logic [bpc_pkg::DataWidth-1:0]     pwdata,
  output logic      [bpc_pkg::DataWidth-1:0]     prdata,
  output logic                                   pready,
  output bpc_pkg::bpc_cal_t                      cal_o
);

  logic [47:0] temp_cal_q;
  logic [63:0] press_low_q;
  logic [63:0] press_high_q;
  logic [15:0] press_last_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q   <= '0;
      press_low_q  <= '0;
      press_high_q <= '0;
      press_last_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        bpc_pkg::RegTempCal:   temp_cal_q   <= pwdata[47:0];
        bpc_pkg::RegPressLow:  press_low_q  <= pwdata;
        bpc_pkg::RegPressHigh: press_high_q <= pwdata;
        bpc_pkg::RegPressLast: press_last_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bpc_pkg::RegTempCal:   prdata = {16'b0, temp_cal_q};
      bpc_pkg::RegPressLow:  prdata = press_low_q;
      bpc_pkg::RegPressHigh: prdata = press_high_q;
      bpc_pkg::RegPressLast: prdata = {48'b0, press_last_q};
      default:               prdata = '0;
    endcase
  end

  assign cal_o.t1 = temp_cal_q[15:0];
  assign cal_o.t2 = temp_cal_q[31:16];
  assign cal_o.t3 = temp_cal_q[47:32];
  assign cal_o.p1 = press_low_q[15:0];
  assign cal_o.p2 = press_low_q[31:16];
  assign cal_o.p3 = press_low_q[47:32];
  assign cal_o.p4 = press_low_q[63:48];
  assign cal_o.p5 = press_high_q[15:0];
  assign cal_o.p6 = press_high_q[31:16];
  assign cal_o.p7 = press_high_q[47:32];
  assign cal_o.p8 = press_high_q[63:48];
  assign cal_o.p9 = press_last_q;

endmodule
`default_nettype wire

[hw/rtl/bpc_front.sv]
// Front pipeline: temperature compensation and pressure divisor and dividend.
`default_nettype none
module bpc_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [19:0]        raw_pressure_i,
  input  wire logic [19:0]        raw_temperature_i,
  input  bpc_pkg::bpc_cal_t       cal_i,
  output logic                    valid_o,
  output bpc_pkg::bpc_side_t      side_o,
  output logic [63:0]             num_mag_o,
  output logic [63:0]             den_mag_o,
  output logic                    neg_o
);

  localparam int unsigned Stages = 12;

  logic [Stages-1:0] vld_q;

  logic signed [31:0] t1x, t2x, t3x;
  logic signed [63:0] p1x, p3x, p4x, p6x;

  logic [20:0]        pd_q [1:9];
  logic [31:0]        tmp_q [5:12];
  logic signed [31:0] d1_q, d2_q, m1_q, m2_q, a1_q, m3_q, fine_q;
  logic signed [33:0] v1_q;
  logic signed [67:0] sq_full;
  logic signed [49:0] v1p5_full, v1p2_full;
  logic signed [63:0] sq_q, v1p5_q, v1p2_q, v1p5b_q, v1p2b_q;
  logic signed [63:0] sqp6_q, sqp3_q, v2_q, y_q, v2b_q, z_q;
  logic signed [63:0] den_q, num_q, dvd_q, den2_q;
  logic               err_q, err2_q;
  logic [63:0]        num_mag_q, den_mag_q;
  logic               neg_q;

  assign t1x = {16'b0, cal_i.t1};
  assign t2x = {{16{cal_i.t2[15]}}, cal_i.t2};
  assign t3x = {{16{cal_i.t3[15]}}, cal_i.t3};
  assign p1x = {48'b0, cal_i.p1};
  assign p3x = bpc_pkg::sext16(cal_i.p3);
  assign p4x = bpc_pkg::sext16(cal_i.p4);
  assign p6x = bpc_pkg::sext16(cal_i.p6);

  assign sq_full   = v1_q * v1_q;
  assign v1p5_full = v1_q * $signed(cal_i.p5);
  assign v1p2_full = v1_q * $signed(cal_i.p2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // temperature, 32-bit wrapping
      pd_q[1] <= bpc_pkg::PressBase - {1'b0, raw_pressure_i};
      d1_q    <= {15'b0, raw_temperature_i[19:3]} - {15'b0, cal_i.t1, 1'b0};
      d2_q    <= {16'b0, raw_temperature_i[19:4]} - t1x;
      m1_q    <= d1_q * t2x;
      m2_q    <= d2_q * d2_q;
      a1_q    <= m1_q >>> 11;
      m3_q    <= (m2_q >>> 12) * t3x;
      fine_q  <= a1_q + (m3_q >>> 14);
      tmp_q[5] <= (fine_q * 32'sd5 + 32'sd128) >>> 8;
      v1_q    <= {{2{fine_q[31]}}, fine_q} - bpc_pkg::TempOffset;
      // pressure divisor and dividend, 64-bit wrapping
      sq_q    <= sq_full[63:0];
      v1p5_q  <= {{14{v1p5_full[49]}}, v1p5_full};
      v1p2_q  <= {{14{v1p2_full[49]}}, v1p2_full};
      sqp6_q  <= sq_q * p6x;
      sqp3_q  <= sq_q * p3x;
      v1p5b_q <= v1p5_q;
      v1p2b_q <= v1p2_q;
      v2_q    <= sqp6_q + (v1p5b_q <<< 17) + (p4x <<< 35);
      y_q     <= (sqp3_q >>> 8) + (v1p2b_q <<< 12) + bpc_pkg::VarBias;
      z_q     <= y_q * p1x;
      v2b_q   <= v2_q;
      den_q   <= z_q >>> 33;
      num_q   <= {12'b0, pd_q[9], 31'b0} - v2b_q;
      dvd_q   <= num_q * bpc_pkg::PressScale;
      den2_q  <= den_q;
      err_q   <= (den_q == '0);
      // sign and magnitude for the unsigned divider
      neg_q     <= dvd_q[63] ^ den2_q[63];
      num_mag_q <= dvd_q[63] ? (64'd0 - dvd_q) : dvd_q;
      den_mag_q <= den2_q[63] ? (64'd0 - den2_q) : den2_q;
      err2_q    <= err_q;
      for (int k = 2; k <= 9; k++) begin
        pd_q[k] <= pd_q[k-1];
      end
      for (int k = 6; k <= 12; k++) begin
        tmp_q[k] <= tmp_q[k-1];
      end
    end
  end

  assign valid_o     = vld_q[Stages-1];
  assign side_o.temp = tmp_q[12];
  assign side_o.err  = err2_q;
  assign num_mag_o   = num_mag_q;
  assign den_mag_o   = den_mag_q;
  assign neg_o       = neg_q;

endmodule
`default_nettype wire

[hw/rtl/bpc_div.sv]
// Pipelined restoring divider: one quotient bit per stage, 64 stages.
`default_nettype none
module bpc_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  bpc_pkg::bpc_side_t      side_i,
  input  wire logic [63:0]        num_i,
  input  wire logic [63:0]        den_i,
  input  wire logic               neg_i,
  output logic                    valid_o,
  output bpc_pkg::bpc_side_t      side_o,
  output logic [63:0]             quot_o,
  output logic                    neg_o
);

  localparam int unsigned Bits = 64;

  logic               vld  [0:Bits];
  logic [63:0]        rem  [0:Bits];
  logic [63:0]        dq   [0:Bits];
  logic [63:0]        dv   [0:Bits];
  logic               ng   [0:Bits];
  bpc_pkg::bpc_side_t sd   [0:Bits];

  assign vld[0] = valid_i;
  assign rem[0] = '0;
  assign dq[0]  = num_i;
  assign dv[0]  = den_i;
  assign ng[0]  = neg_i;
  assign sd[0]  = side_i;

  for (genvar k = 0; k < Bits; k++) begin : g_stage
    logic               vld_q;
    logic [63:0]        rem_q, dq_q, dv_q;
    logic               ng_q;
    bpc_pkg::bpc_side_t sd_q;
    logic [64:0]        cand, diff;
    logic               ge;

    // shift in the next dividend bit and try the subtract
    assign cand = {rem[k], dq[k][63]};
    assign diff = cand - {1'b0, dv[k]};
    assign ge   = ~diff[64];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= ge ? diff[63:0] : cand[63:0];
        dq_q  <= {dq[k][62:0], ge};
        dv_q  <= dv[k];
        ng_q  <= ng[k];
        sd_q  <= sd[k];
      end
    end

    assign vld[k+1] = vld_q;
    assign rem[k+1] = rem_q;
    assign dq[k+1]  = dq_q;
    assign dv[k+1]  = dv_q;
    assign ng[k+1]  = ng_q;
    assign sd[k+1]  = sd_q;
  end

  assign valid_o = vld[Bits];
  assign side_o  = sd[Bits];
  assign quot_o  = dq[Bits];
  assign neg_o   = ng[Bits];

endmodule
`default_nettype wire

[hw/rtl/bpc_back.sv]
// Back pipeline: quotient sign, second-order correction and output register.
`default_nettype none
module bpc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  bpc_pkg::bpc_side_t      side_i,
  input  wire logic [63:0]        quot_i,
  input  wire logic               neg_i,
  input  bpc_pkg::bpc_cal_t       cal_i,
  output logic                    valid_o,
  output logic [31:0]             temp_o,
  output logic [31:0]             press_o,
  output logic                    err_o
);

  localparam int unsigned Stages = 5;

  logic [Stages-1:0]  vld_q;
  bpc_pkg::bpc_side_t sd_q [1:4];
  logic signed [63:0] p7x, p8x, p9x;
  logic signed [63:0] q_q, q2_q, q3_q, q4_q, ph_q, x_q, w2_q, w2b_q, w2c_q, w1_q;
  logic signed [63:0] ph, sum, res;
  logic [63:0]        ll_q, prod;
  logic [31:0]        lh_q, hl_q;
  logic [31:0]        temp_q, press_q;
  logic               err_q;

  assign p7x  = bpc_pkg::sext16(cal_i.p7);
  assign p8x  = bpc_pkg::sext16(cal_i.p8);
  assign p9x  = bpc_pkg::sext16(cal_i.p9);
  assign ph   = q_q >>> 13;
  // low 64 bits of x * ph from three 32-bit partial products
  assign prod = ll_q + {lh_q + hl_q, 32'b0};
  assign sum  = q4_q + w1_q + w2c_q;
  assign res  = (sum >>> 8) + (p7x <<< 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q     <= neg_i ? (64'sd0 - $signed(quot_i)) : $signed(quot_i);
      sd_q[1] <= side_i;
      ph_q    <= ph;
      x_q     <= p9x * ph;
      w2_q    <= (p8x * q_q) >>> 19;
      q2_q    <= q_q;
      sd_q[2] <= sd_q[1];
      ll_q    <= x_q[31:0] * ph_q[31:0];
      lh_q    <= x_q[31:0] * ph_q[63:32];
      hl_q    <= x_q[63:32] * ph_q[31:0];
      q3_q    <= q2_q;
      w2b_q   <= w2_q;
      sd_q[3] <= sd_q[2];
      w1_q    <= $signed(prod) >>> 25;
      q4_q    <= q3_q;
      w2c_q   <= w2b_q;
      sd_q[4] <= sd_q[3];
      // zero both results on a zero divisor
      temp_q  <= sd_q[4].err ? 32'd0 : sd_q[4].temp;
      press_q <= sd_q[4].err ? 32'd0 : res[31:0];
      err_q   <= sd_q[4].err;
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign temp_o  = temp_q;
  assign press_o = press_q;
  assign err_o   = err_q;

endmodule
`default_nettype wire

[tb/sv/baro_pressure_temp_compensation_tb.sv]
// Testbench: barometer compensation stream checked against its own integer predictor.
module baro_pressure_temp_compensation_tb;

  typedef struct {
    logic [19:0] press;
    logic [19:0] temp;
  } raw_pair_t;

  typedef struct {
    logic [31:0] temp_centi;
    logic [31:0] press_q24_8;
    logic        div_err;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bpc_pkg::AddrWidth-1:0] paddr = '0;
  logic [bpc_pkg::DataWidth-1:0] pwdata = '0;
  logic [bpc_pkg::DataWidth-1:0] prdata;
  logic pready;

  bpc_in_if  in_if ();
  bpc_out_if out_if ();

  baro_pressure_temp_compensation DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk_i = ~clk_i;

  // Calibration copy held by the predictor
  logic [63:0] cal_temp, cal_press_lo, cal_press_hi, cal_press_last;

  raw_pair_t raw_pending[$];
  reading_t  readings_due[$];
  int unsigned send_idle_pct, recv_stall_pct;
  int errors;
  int quiet_cycles;
  bit in_moved;

  initial begin
    in_if.valid = 1'b0;
    in_if.raw_pressure = '0;
    in_if.raw_temperature = '0;
    out_if.ready = 1'b0;
    cal_temp = '0;
    cal_press_lo = '0;
    cal_press_hi = '0;
    cal_press_last = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    quiet_cycles = 0;
    in_moved = 1'b0;
  end

  function automatic logic [63:0] sx16(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] quot_trunc(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic reading_t compensate(input logic [19:0] adc_p, input logic [19:0] adc_t);
    logic [31:0] t1, t2, t3, d1, d2, a1, a2, tmp, fine, temp;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, p, ph, w1, w2;
    reading_t r;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    p1 = {48'd0, cal_press_lo[15:0]};
    p2 = sx16(cal_press_lo[31:16]);
    p3 = sx16(cal_press_lo[47:32]);
    p4 = sx16(cal_press_lo[63:48]);
    p5 = sx16(cal_press_hi[15:0]);
    p6 = sx16(cal_press_hi[31:16]);
    p7 = sx16(cal_press_hi[47:32]);
    p8 = sx16(cal_press_hi[63:48]);
    p9 = sx16(cal_press_last[15:0]);
    d1 = {12'd0, adc_t} >> 3;
    d1 = d1 - (t1 << 1);
    tmp = d1 * t2;
    a1 = sra32(tmp, 11);
    d2 = ({12'd0, adc_t} >> 4) - t1;
    tmp = d2 * d2;
    tmp = sra32(tmp, 12);
    tmp = tmp * t3;
    a2 = sra32(tmp, 14);
    fine = a1 + a2;
    tmp = fine * 32'd5 + 32'd128;
    temp = sra32(tmp, 8);
    v1 = {{32{fine[31]}}, fine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
    if (v1 == 64'd0) begin
      r.temp_centi = '0;
      r.press_q24_8 = '0;
      r.div_err = 1'b1;
      return r;
    end
    p = 64'd1048576 - {44'd0, adc_p};
    p = quot_trunc(((p << 31) - v2) * 64'd3125, v1);
    ph = sra64(p, 13);
    w1 = sra64(p9 * ph * ph, 25);
    w2 = sra64(p8 * p, 19);
    p = sra64(p + w1 + w2, 8) + (p7 << 4);
    r.temp_centi = temp;
    r.press_q24_8 = p[31:0];
    r.div_err = 1'b0;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (errors < 40) $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic write_cal(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bpc_pkg::RegTempCal:   cal_temp = val & 64'h0000_FFFF_FFFF_FFFF;
      bpc_pkg::RegPressLow:  cal_press_lo = val;
      bpc_pkg::RegPressHigh: cal_press_hi = val;
      bpc_pkg::RegPressLast: cal_press_last = val & 64'h0000_0000_0000_FFFF;
      default: ;
    endcase
  endtask

  // Input transfers: predict and queue the reading, advance the pending list
  always @(posedge clk_i) begin
    in_moved = 1'b0;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        readings_due.push_back(compensate(in_if.raw_pressure, in_if.raw_temperature));
        void'(raw_pending.pop_front());
        in_moved = 1'b1;
      end
    end
  end

  // Output transfers: compare with the oldest reading due
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (readings_due.size() == 0) begin
        report("unexpected transfer", out_if.pressure_q24_8, '0);
      end else begin
        want = readings_due.pop_front();
        if (out_if.temperature_centi !== want.temp_centi)
          report("temperature_centi", out_if.temperature_centi, want.temp_centi);
        if (out_if.pressure_q24_8 !== want.press_q24_8)
          report("pressure_q24_8", out_if.pressure_q24_8, want.press_q24_8);
        if (out_if.divide_error !== want.div_err)
          report("divide_error", {31'd0, out_if.divide_error}, {31'd0, want.div_err});
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_moved) begin
        if (raw_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.raw_pressure <= raw_pending[0].press;
          in_if.raw_temperature <= raw_pending[0].temp;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= 5000) begin
      $display("baro_pressure_temp_compensation_tb NOT OK");
      $finish;
    end
  end

  task automatic queue_pair(input logic [19:0] rp, input logic [19:0] rt);
    raw_pair_t s;
    s.press = rp;
    s.temp = rt;
    raw_pending.push_back(s);
  endtask

  task automatic drain();
    while (raw_pending.size() != 0 || readings_due.size() != 0) @(posedge clk_i);
    repeat (90) @(posedge clk_i);
  endtask

  localparam logic [63:0] TypTemp = {16'h0000, 16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TypLow  = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TypHigh = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [63:0] TypLast = 64'd6000;

  initial begin
    logic [63:0] regs[4];
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: regs = '{0, 0, 0, 0};
        1: regs = '{TypTemp, TypLow, TypHigh, TypLast};
        2: regs = '{'1, '1, '1, '1};
        3: regs = '{64'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
                    64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF};
        4: regs = '{TypTemp, TypLow & ~64'hFFFF, TypHigh, TypLast};
        5: regs = '{64'h8000_8000_0000, 64'h8000_8000_8000_0001,
                    64'h8000_8000_8000_8000, 64'h8000};
        default: regs = '{{$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom}};
      endcase
      // reset values are checked as they stand in the first phase
      if (ph != 0) begin
        write_cal(bpc_pkg::RegTempCal, regs[0]);
        write_cal(bpc_pkg::RegPressLow, regs[1]);
        write_cal(bpc_pkg::RegPressHigh, regs[2]);
        write_cal(bpc_pkg::RegPressLast, regs[3]);
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (ph < 2) begin
        queue_pair(20'h00000, 20'h00000);
        queue_pair(20'hFFFFF, 20'hFFFFF);
        queue_pair(20'h00000, 20'hFFFFF);
        queue_pair(20'hFFFFF, 20'h00000);
        queue_pair(20'hAAAAA, 20'h55555);
        queue_pair(20'h55555, 20'hAAAAA);
        queue_pair(20'h80000, 20'h7FFFF);
        queue_pair(20'd415148, 20'd519888);
        queue_pair(20'd200000, 20'd600000);
      end
      for (int k = 0; k < 215; k++) begin
        if ($urandom_range(9) < 7)
          queue_pair(20'($urandom_range(700000, 200000)), 20'($urandom_range(600000, 400000)));
        else
          queue_pair(20'($urandom), 20'($urandom));
      end
    end
    drain();
    if (errors == 0)
      $display("baro_pressure_temp_compensation_tb OK");
    else
      $display("baro_pressure_temp_compensation_tb NOT OK");
    $finish;
  end

endmodule
